[hw/rtl/wss_pkg.sv]
// Package for the wildcard substring search block.
// Holds the sizes, register indexes, queue entry type and pattern helpers.
// No dependencies.
package wss_pkg;

    // Pattern storage and position counter sizes.
    localparam int unsigned PATTERN_MAX    = 16;
    localparam int unsigned POSITION_WIDTH = 16;
    localparam int unsigned LEN_WIDTH      = $clog2(PATTERN_MAX + 1);
    localparam int unsigned BIT_IDX_WIDTH  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int unsigned CFG_WIDTH      = 64;
    localparam int unsigned CFG_IDX_WIDTH  = 2;
    localparam int unsigned LOC_WIDTH      = 16;

    // Queue between the classifier and the matcher.
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QPTR_WIDTH     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_WIDTH     = $clog2(QUEUE_DEPTH + 1);

    // Special byte values.
    localparam logic [7:0] WILDCARD_BYTE   = 8'h3F;
    localparam logic [7:0] TERMINATOR_BYTE = 8'h00;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2
    } t_cfg_idx;

    typedef logic [PATTERN_MAX-1:0][7:0] t_pattern;
    typedef logic [PATTERN_MAX-1:0]      t_mask;
    typedef logic [POSITION_WIDTH-1:0]   t_pos;

    // One classified text item as it waits in the queue.
    typedef struct packed {
        logic  term;
        t_mask mask;
    } t_cls;

    // Pattern length as used: values above the maximum are clipped.
    function automatic logic [LEN_WIDTH-1:0] eff_len(input logic [4:0] len);
        logic [LEN_WIDTH-1:0] res;
        if (32'(len) > PATTERN_MAX) begin
            res = LEN_WIDTH'(PATTERN_MAX);
        end else begin
            res = LEN_WIDTH'(len);
        end
        return res;
    endfunction

endpackage

[hw/rtl/wildcard_substring_search.sv]
// Top level of the wildcard substring search block.
// Holds the pattern registers and joins classifier, queue and matcher.
// Depends on wss_pkg, wss_front, wss_fifo and wss_back.
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+------------------------
//  text     | in        | i_in_valid / o_in_ready      | i_text_byte
//  result   | out       | o_out_valid / i_out_ready    | o_found, o_location
//  config   | in        | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// One text byte is taken per cycle while the queue is not full; a result is offered
// at the earliest once its item has been written into the queue, popped by the
// matcher and loaded into the result register.
// The queue holds two items, so input stalls only when the matcher is held up
// by a result that is not taken. Synchronous active-low reset clears the
// search state, the queue and the pattern registers.
module wildcard_substring_search (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wss_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [wss_pkg::CFG_WIDTH-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_text_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [wss_pkg::LOC_WIDTH-1:0]     o_location
);
    import wss_pkg::*;

    logic [CFG_WIDTH-1:0] r_pat_low;
    logic [CFG_WIDTH-1:0] r_pat_high;
    logic [4:0]           r_pat_len;
    t_pattern             pattern;
    logic [LEN_WIDTH-1:0] len;
    t_cls                 cls_in;
    t_cls                 cls_out;
    logic                 q_full;
    logic                 q_empty;
    logic                 push;
    logic                 pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pat_low  <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pat_high <= i_cfg_data;
                CFG_PATTERN_LEN:  r_pat_len  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign pattern    = t_pattern'({r_pat_high, r_pat_low});
    assign len        = eff_len(r_pat_len);
    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    wss_front u_front (
        .i_text_byte (i_text_byte),
        .i_pattern   (pattern),
        .i_len       (len),
        .o_cls       (cls_in)
    );

    wss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .i_pop   (pop),
        .o_data  (cls_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    wss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls       (cls_out),
        .i_cls_valid (!q_empty),
        .o_pop       (pop),
        .i_len       (len),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_location  (o_location)
    );

endmodule

[hw/rtl/wss_front.sv]
// Classifier of the wildcard substring search block.
// Flags the terminator and compares a text byte with every pattern byte.
// Depends on wss_pkg.
module wss_front (
    input  logic [7:0]                    i_text_byte,
    input  wss_pkg::t_pattern             i_pattern,
    input  logic [wss_pkg::LEN_WIDTH-1:0] i_len,
    output wss_pkg::t_cls                 o_cls
);
    import wss_pkg::*;

    // One compare per pattern byte; bytes beyond the length never match.
    always_comb begin
        o_cls.term = (i_text_byte == TERMINATOR_BYTE);
        for (int j = 0; j < PATTERN_MAX; j++) begin
            o_cls.mask[j] = (32'(j) < 32'(i_len)) &&
                            ((i_pattern[j] == WILDCARD_BYTE) || (i_pattern[j] == i_text_byte));
        end
    end

endmodule

[hw/rtl/wss_fifo.sv]
// Short queue between the classifier and the matcher.
// Holds classified items so that each side can stall on its own.
// Depends on wss_pkg.
module wss_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wss_pkg::t_cls i_data,
    input  logic          i_pop,
    output wss_pkg::t_cls o_data,
    output logic          o_full,
    output logic          o_empty
);
    import wss_pkg::*;

    t_cls                  r_mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_WIDTH-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_WIDTH'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (32'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/wss_back.sv]
// Matcher of the wildcard substring search block.
// Runs the shift-and update, the position count and the result register.
// Depends on wss_pkg.
module wss_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wss_pkg::t_cls                 i_cls,
    input  logic                          i_cls_valid,
    output logic                          o_pop,
    input  logic [wss_pkg::LEN_WIDTH-1:0] i_len,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [wss_pkg::LOC_WIDTH-1:0] o_location
);
    import wss_pkg::*;

    t_mask                 r_pm, n_pm;
    t_pos                  r_pos, n_pos;
    logic                  r_done, n_done;
    logic                  r_out_valid, n_out_valid;
    logic                  r_found, n_found;
    logic [LOC_WIDTH-1:0]  r_loc, n_loc;
    t_mask                 shifted;
    logic [BIT_IDX_WIDTH-1:0] top_bit;
    t_pos                  back_off;

    // Take an item whenever the result register is free or being emptied.
    assign o_pop = i_cls_valid && (!r_out_valid || i_out_ready);

    assign shifted  = ((r_pm << 1) | t_mask'(1)) & i_cls.mask;
    assign top_bit  = BIT_IDX_WIDTH'(i_len - 1'b1);
    assign back_off = POSITION_WIDTH'(i_len - 1'b1);

    // Next state of the search and of the result register.
    always_comb begin
        n_pm        = r_pm;
        n_pos       = r_pos;
        n_done      = r_done;
        n_out_valid = r_out_valid && !i_out_ready;
        n_found     = r_found;
        n_loc       = r_loc;
        if (o_pop) begin
            if (i_cls.term) begin
                n_pm   = '0;
                n_pos  = '0;
                n_done = 1'b0;
                if (!r_done) begin
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_loc       = LOC_WIDTH'(r_pos);
                end
            end else begin
                if (r_pos != '1) begin
                    n_pos = r_pos + 1'b1;
                end
                if (!r_done) begin
                    if (i_len == '0) begin
                        n_done      = 1'b1;
                        n_pm        = '0;
                        n_out_valid = 1'b1;
                        n_found     = 1'b1;
                        n_loc       = LOC_WIDTH'(r_pos);
                    end else begin
                        n_pm = shifted;
                        if (shifted[top_bit]) begin
                            n_done      = 1'b1;
                            n_out_valid = 1'b1;
                            n_found     = 1'b1;
                            n_loc       = (r_pos >= back_off) ?
                                          LOC_WIDTH'(r_pos - back_off) : '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm        <= '0;
            r_pos       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pm        <= n_pm;
            r_pos       <= n_pos;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_loc   <= n_loc;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_location  = r_loc;

endmodule
